// ----- rtl/rrss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types, sizes and codes of the round robin slice scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

  // Process table size and derived index and count widths.
  localparam int unsigned MAX_PROCESSES = 16;
  localparam int unsigned IDX_W         = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W         = IDX_W + 1;

  // Field widths.
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned QUANTUM_W = 16;
  localparam int unsigned TIME_W    = 20;
  localparam int unsigned TOTAL_W   = 24;
  localparam int unsigned PIDX_W    = 4;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [BURST_W-1:0]   burst_t;
  typedef logic [QUANTUM_W-1:0] quantum_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [PIDX_W-1:0]    pidx_t;

  localparam quantum_t QUANTUM_RESET = quantum_t'(4);
  localparam cnt_t     CNT_FULL      = cnt_t'(MAX_PROCESSES);
  localparam idx_t     IDX_LAST      = idx_t'(MAX_PROCESSES - 1);

  // Command and status codes.
  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_RUN = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Control of the ready queue memory.
  typedef struct packed {
    logic rd_en;
    logic pop;
    logic push;
    idx_t push_idx;
  } queue_ctrl_t;

  // One entry of the burst table.
  typedef struct packed {
    burst_t orig;
    burst_t rem;
  } bt_entry_t;

  // Control of the burst table memory.
  typedef struct packed {
    logic      rd_en;
    idx_t      rd_addr;
    logic      wr_en;
    idx_t      wr_addr;
    bt_entry_t wr_data;
  } bt_ctrl_t;

endpackage

// ----- rtl/rrss_ready_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_ready_queue
// Circular FIFO of process indices in a synchronous memory, with head, tail
// and fill count. The entry at the head is read through an output register.
// ----------------------------------------------------------------------------
module rrss_ready_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrss_pkg::queue_ctrl_t ctrl_i,
  output rrss_pkg::idx_t       head_idx_o,
  output rrss_pkg::cnt_t       count_o
);

  rrss_pkg::idx_t mem_q [rrss_pkg::MAX_PROCESSES];
  rrss_pkg::idx_t rdata_q;
  rrss_pkg::idx_t head_q, head_d;
  rrss_pkg::idx_t tail_q, tail_d;
  rrss_pkg::cnt_t count_q, count_d;

  // Memory: one write at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= ctrl_i.push_idx;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[head_q];
    end
  end

  // Pointer and count updates; a pop and a push may happen together.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == rrss_pkg::IDX_LAST) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == rrss_pkg::IDX_LAST) ? '0 : tail_q + 1'b1;
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign head_idx_o = rdata_q;
  assign count_o    = count_q;

  // The fill count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rrss_pkg::CNT_FULL)
    else $error("ready queue count above table size");

  // No pop from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> count_q != '0)
    else $error("ready queue popped while empty");

  // No push into a full queue unless an entry leaves in the same cycle.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push && !ctrl_i.pop) |-> count_q < rrss_pkg::CNT_FULL)
    else $error("ready queue pushed while full");

  // A lone push grows the count by exactly one.
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push && !ctrl_i.pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("ready queue count did not follow a push");

endmodule

// ----- rtl/rrss_burst_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_burst_table
// Per-process original and remaining burst in a synchronous memory with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module rrss_burst_table (
  input  logic               clk_i,
  input  rrss_pkg::bt_ctrl_t ctrl_i,
  output rrss_pkg::burst_t   orig_o,
  output rrss_pkg::burst_t   rem_o
);

  rrss_pkg::bt_entry_t mem_q [rrss_pkg::MAX_PROCESSES];
  rrss_pkg::bt_entry_t rdata_q;

  // Write and registered read of one entry each per cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[ctrl_i.rd_addr];
    end
  end

  assign orig_o = rdata_q.orig;
  assign rem_o  = rdata_q.rem;

endmodule

// ----- rtl/round_robin_slice_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Sequence: an add word, or a run word on an empty queue, goes from acceptance
// straight to write-back; a run word on a nonempty queue takes the steps
// ready queue read, then burst table read, then write-back with the result.
// One word in flight; a new word is taken the cycle after the result is
// loaded, and write-back waits until the output register is free. Reset
// (async, active low) clears pointers, counters, time, totals; quantum is 4.
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_unit
// Round robin scheduler: enrolls processes and serves one time slice per run
// word from a FIFO ready queue, tracking time and waiting/turnaround totals.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel (quantum).
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] burst_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  process_index_o,
  output logic [19:0] slice_end_time_o,
  output logic        finished_o,
  output logic [19:0] waiting_time_o,
  output logic [19:0] turnaround_time_o,
  output logic [23:0] total_waiting_o,
  output logic [23:0] total_turnaround_o,
  output logic        queue_empty_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  rrss_pkg::quantum_t quantum_q;
  rrss_pkg::cmd_e     cmd_q;
  rrss_pkg::burst_t   burst_q;
  rrss_pkg::cnt_t     pcount_q;
  rrss_pkg::time_t    time_q, time_d;
  rrss_pkg::total_t   sum_wait_q, sum_wait_d;
  rrss_pkg::total_t   sum_turn_q, sum_turn_d;

  // Output word register.
  logic                  out_valid_q;
  rrss_pkg::status_e     status_q, status_d;
  rrss_pkg::pidx_t       pidx_q, pidx_d;
  rrss_pkg::time_t       end_time_q;
  logic                  fin_q, fin_d;
  rrss_pkg::time_t       wait_q, wait_d;
  rrss_pkg::time_t       turn_q, turn_d;
  logic                  qempty_q, qempty_d;

  rrss_pkg::queue_ctrl_t q_ctrl;
  rrss_pkg::idx_t        q_head_idx;
  rrss_pkg::cnt_t        q_count;
  rrss_pkg::bt_ctrl_t    bt_ctrl;
  rrss_pkg::burst_t      bt_orig;
  rrss_pkg::burst_t      bt_rem;

  logic                  in_fire;
  logic                  out_free;
  logic                  commit;
  logic                  add_ok;
  logic                  fits;
  rrss_pkg::burst_t      step;
  logic [rrss_pkg::TIME_W:0]  time_sum;
  logic [rrss_pkg::TOTAL_W:0] wsum;
  logic [rrss_pkg::TOTAL_W:0] tsum;
  rrss_pkg::time_t       run_time;
  rrss_pkg::time_t       run_wait;
  rrss_pkg::cnt_t        count_after;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = (state_q == S_RESP) && out_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Quantum register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= rrss_pkg::QUANTUM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      quantum_q <= rrss_pkg::quantum_t'(cfg_data_i);
    end
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= rrss_pkg::cmd_e'(command_i);
      burst_q <= rrss_pkg::burst_t'(burst_i);
    end
  end

  // Sequencer: queue read at acceptance, burst read next for a served run, then write-back.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (command_i == rrss_pkg::CMD_RUN && q_count != '0) begin
            state_d = S_HEAD;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_HEAD: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Slice arithmetic on the served process.
  assign fits     = (bt_rem <= quantum_q);
  assign step     = fits ? bt_rem : rrss_pkg::burst_t'(quantum_q);
  assign time_sum = {1'b0, time_q} + (rrss_pkg::TIME_W + 1)'(step);
  assign run_time = time_sum[rrss_pkg::TIME_W] ? '1 : time_sum[rrss_pkg::TIME_W-1:0];
  assign run_wait = (run_time >= rrss_pkg::time_t'(bt_orig))
                  ? run_time - rrss_pkg::time_t'(bt_orig) : '0;
  assign wsum     = {1'b0, sum_wait_q} + (rrss_pkg::TOTAL_W + 1)'(run_wait);
  assign tsum     = {1'b0, sum_turn_q} + (rrss_pkg::TOTAL_W + 1)'(run_time);
  assign add_ok   = (pcount_q != rrss_pkg::CNT_FULL);

  // Memory control and next values of the result and the state.
  always_comb begin
    q_ctrl          = '0;
    bt_ctrl         = '0;
    q_ctrl.rd_en    = in_fire && (command_i == rrss_pkg::CMD_RUN);
    bt_ctrl.rd_en   = (state_q == S_HEAD);
    bt_ctrl.rd_addr = q_head_idx;
    time_d      = time_q;
    sum_wait_d  = sum_wait_q;
    sum_turn_d  = sum_turn_q;
    status_d    = rrss_pkg::ST_OK;
    pidx_d      = '0;
    fin_d       = 1'b0;
    wait_d      = '0;
    turn_d      = '0;
    count_after = q_count;
    if (cmd_q == rrss_pkg::CMD_ADD) begin
      if (add_ok) begin
        pidx_d            = rrss_pkg::pidx_t'(pcount_q);
        count_after       = q_count + 1'b1;
        q_ctrl.push       = commit;
        q_ctrl.push_idx   = rrss_pkg::idx_t'(pcount_q);
        bt_ctrl.wr_en     = commit;
        bt_ctrl.wr_addr   = rrss_pkg::idx_t'(pcount_q);
        bt_ctrl.wr_data   = '{orig: burst_q, rem: burst_q};
      end else begin
        status_d = rrss_pkg::ST_FULL;
      end
    end else if (q_count == '0) begin
      status_d = rrss_pkg::ST_EMPTY;
    end else begin
      pidx_d          = rrss_pkg::pidx_t'(q_head_idx);
      time_d          = run_time;
      q_ctrl.pop      = commit;
      bt_ctrl.wr_en   = commit;
      bt_ctrl.wr_addr = q_head_idx;
      if (fits) begin
        count_after     = q_count - 1'b1;
        fin_d           = 1'b1;
        wait_d          = run_wait;
        turn_d          = run_time;
        sum_wait_d      = wsum[rrss_pkg::TOTAL_W] ? '1 : wsum[rrss_pkg::TOTAL_W-1:0];
        sum_turn_d      = tsum[rrss_pkg::TOTAL_W] ? '1 : tsum[rrss_pkg::TOTAL_W-1:0];
        bt_ctrl.wr_data = '{orig: bt_orig, rem: '0};
      end else begin
        q_ctrl.push     = commit;
        q_ctrl.push_idx = q_head_idx;
        bt_ctrl.wr_data = '{orig: bt_orig, rem: bt_rem - rrss_pkg::burst_t'(quantum_q)};
      end
    end
    qempty_d = (count_after == '0);
  end

  // Control state, time and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pcount_q    <= '0;
      time_q      <= '0;
      sum_wait_q  <= '0;
      sum_turn_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        time_q      <= time_d;
        sum_wait_q  <= sum_wait_d;
        sum_turn_q  <= sum_turn_d;
        out_valid_q <= 1'b1;
        if (cmd_q == rrss_pkg::CMD_ADD && add_ok) begin
          pcount_q <= pcount_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q   <= status_d;
      pidx_q     <= pidx_d;
      end_time_q <= time_d;
      fin_q      <= fin_d;
      wait_q     <= wait_d;
      turn_q     <= turn_d;
      qempty_q   <= qempty_d;
    end
  end

  rrss_ready_queue u_ready_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (q_ctrl),
    .head_idx_o (q_head_idx),
    .count_o    (q_count)
  );

  rrss_burst_table u_burst_table (
    .clk_i  (clk_i),
    .ctrl_i (bt_ctrl),
    .orig_o (bt_orig),
    .rem_o  (bt_rem)
  );

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign process_index_o    = pidx_q;
  assign slice_end_time_o   = end_time_q;
  assign finished_o         = fin_q;
  assign waiting_time_o     = wait_q;
  assign turnaround_time_o  = turn_q;
  assign total_waiting_o    = sum_wait_q;
  assign total_turnaround_o = sum_turn_q;
  assign queue_empty_o      = qempty_q;

  // A new result word appears only after the write-back state.
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result word loaded outside write-back");

  // The process table never holds more entries than its size.
  a_pcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q <= rrss_pkg::CNT_FULL)
    else $error("process count above table size");

  // A finished slice reports success and its turnaround equals the end time.
  a_fin_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fin_q) |-> (status_q == rrss_pkg::ST_OK && turn_q == end_time_q))
    else $error("finished word with inconsistent fields");

  // The burst table is written only during write-back.
  a_wr_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bt_ctrl.wr_en |-> state_q == S_RESP)
    else $error("burst table written outside write-back");

endmodule
